// ----- hdl/gsef_pkg.sv -----
// Shared constants and types for the grayscale Sobel edge filter.
package gsef_pkg;

  // Pixel and luma widths
  localparam int PIX_W = 8;
  localparam int LUMA_SUM_W = 24;

  // BT.709 luma weights in unsigned Q16; they sum to 65536
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // Frame geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;
  localparam logic [DIM_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  // Configuration bus
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

// ----- hdl/grayscale_sobel_edge_filter.sv -----
// Streaming 3x3 Sobel edge filter on BT.709 luma, with APB setup registers.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  pixel    | pixel_valid / pixel_ready   | red, green, blue
//  result   | result_valid / result_ready | edge_magnitude, last_of_frame
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready = 1)
//
// One pixel per clock sustained unless result_ready stalls. The two line buffers are
// single write / single read RAMs read at accept and written one stage later, which
// sets the one-per-cycle pace. A result moves through the stage-1, stage-2 and output
// registers. Synchronous reset clears counters, window and valid bits; line RAMs need
// no clearing. Each stage moves whenever the stage after it is empty or moving, so
// bubbles collapse; while a result waits on result_ready, input is taken into a bubble.
module grayscale_sobel_edge_filter #(
  parameter int MAX_WIDTH = gsef_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel channel
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [gsef_pkg::PIX_W-1:0]       red,
  input  logic [gsef_pkg::PIX_W-1:0]       green,
  input  logic [gsef_pkg::PIX_W-1:0]       blue,
  // result channel
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [gsef_pkg::PIX_W-1:0]       edge_magnitude,
  output logic                             last_of_frame,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gsef_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [gsef_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gsef_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PW = gsef_pkg::PIX_W;
  localparam int RW = gsef_pkg::ROW_W;
  localparam int DW = gsef_pkg::DIM_W;
  localparam int LUMA_SUM_W = gsef_pkg::LUMA_SUM_W;

  // configuration registers
  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;
  logic          cfg_write;
  gsef_pkg::reg_idx_t cfg_idx;

  // frame position
  logic [COL_W-1:0] column_count;
  logic [RW-1:0]    row_count;
  logic [COL_W-1:0] col_last;
  logic [RW-1:0]    row_last;
  logic [31:0]      width_ext;
  logic [31:0]      height_ext;

  // pipeline control
  logic accept;
  logic adv1;
  logic adv2;
  logic adv3;
  logic move1;
  logic v1;
  logic v2;

  // stage 1: input register and line buffer read data
  logic [PW-1:0]    red1;
  logic [PW-1:0]    green1;
  logic [PW-1:0]    blue1;
  logic [COL_W-1:0] col1;
  logic             emit1;
  logic             last1;
  logic [PW-1:0]    top1;
  logic [PW-1:0]    mid1;
  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [PW-1:0]    luma1;

  // line buffers
  logic [PW-1:0] older_line [MAX_WIDTH];
  logic [PW-1:0] newer_line [MAX_WIDTH];

  // window: two older columns, top/mid/bottom
  logic [PW-1:0] window_columns [6];

  // stage 2: full 3x3 neighborhood (middle-middle not needed)
  logic [PW-1:0] tl2, ml2, bl2, tm2, bm2, tr2, mr2, br2;
  logic          last2;

  // gradient logic
  logic [PW+1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [PW+1:0] gx_abs, gy_abs;
  logic [PW+2:0] grad_sum;
  logic [PW-1:0] grad_sat;

  // ---------------------------------------------------------------------------
  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = gsef_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gsef_pkg::WIDTH_RESET;
      frame_height <= gsef_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        gsef_pkg::REG_WIDTH:  frame_width  <= pwdata[DW-1:0];
        gsef_pkg::REG_HEIGHT: frame_height <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gsef_pkg::REG_WIDTH:  prdata = {{(gsef_pkg::APB_DATA_W-DW){1'b0}}, frame_width};
      gsef_pkg::REG_HEIGHT: prdata = {{(gsef_pkg::APB_DATA_W-DW){1'b0}}, frame_height};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // effective geometry, clamped to [3, max], as last column / last row
  assign width_ext  = {{(32-DW){1'b0}}, frame_width};
  assign height_ext = {{(32-DW){1'b0}}, frame_height};

  always_comb begin
    if (width_ext < 32'd3) begin
      col_last = COL_W'(2);
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_ext - 32'd1);
    end
    if (height_ext < 32'd3) begin
      row_last = RW'(2);
    end else if (height_ext > 32'(gsef_pkg::MAX_HEIGHT)) begin
      row_last = RW'(gsef_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last = RW'(height_ext - 32'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // stage advance: a stage moves when the next one is empty or moving
  assign adv3        = !result_valid || result_ready;
  assign adv2        = !v2 || adv3;
  assign adv1        = !v1 || adv2;
  assign pixel_ready = adv1;
  assign accept      = pixel_valid && pixel_ready;
  assign move1       = v1 && adv2;

  // raster counters; a register write starts a new frame
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count == col_last) begin
        column_count <= '0;
        row_count    <= (row_count == row_last) ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // stage 1 valid and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red1   <= red;
      green1 <= green;
      blue1  <= blue;
      col1   <= column_count;
      emit1  <= (row_count >= RW'(2)) && (column_count >= COL_W'(2));
      last1  <= (row_count == row_last) && (column_count == col_last);
    end
  end

  // line buffers: read at accept, write back when the pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      top1 <= older_line[column_count];
      mid1 <= newer_line[column_count];
    end
    if (move1) begin
      older_line[col1] <= mid1;
      newer_line[col1] <= luma1;
    end
  end

  // luma: Q16 weighted sum, truncated
  assign luma_sum = LUMA_SUM_W'(red1)   * LUMA_SUM_W'(gsef_pkg::COEF_R)
                  + LUMA_SUM_W'(green1) * LUMA_SUM_W'(gsef_pkg::COEF_G)
                  + LUMA_SUM_W'(blue1)  * LUMA_SUM_W'(gsef_pkg::COEF_B);
  assign luma1 = luma_sum[LUMA_SUM_W-1 -: PW];

  // window shift, one column per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_columns[i] <= '0;
      end
    end else if (move1) begin
      window_columns[0] <= window_columns[3];
      window_columns[1] <= window_columns[4];
      window_columns[2] <= window_columns[5];
      window_columns[3] <= top1;
      window_columns[4] <= mid1;
      window_columns[5] <= luma1;
    end
  end

  // stage 2: only interior centres go on
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      tl2   <= window_columns[0];
      ml2   <= window_columns[1];
      bl2   <= window_columns[2];
      tm2   <= window_columns[3];
      bm2   <= window_columns[5];
      tr2   <= top1;
      mr2   <= mid1;
      br2   <= luma1;
      last2 <= last1;
    end
  end

  // Sobel gradients, L1 magnitude, saturated
  assign gx_pos = {2'b00, tr2} + {1'b0, mr2, 1'b0} + {2'b00, br2};
  assign gx_neg = {2'b00, tl2} + {1'b0, ml2, 1'b0} + {2'b00, bl2};
  assign gy_pos = {2'b00, bl2} + {1'b0, bm2, 1'b0} + {2'b00, br2};
  assign gy_neg = {2'b00, tl2} + {1'b0, tm2, 1'b0} + {2'b00, tr2};
  assign gx_abs = (gx_pos > gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
  assign gy_abs = (gy_pos > gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
  assign grad_sum = {1'b0, gx_abs} + {1'b0, gy_abs};
  assign grad_sat = (grad_sum[PW+2:PW] != 3'b000) ? {PW{1'b1}} : grad_sum[PW-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv3) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      edge_magnitude <= grad_sat;
      last_of_frame  <= last2;
    end
  end

endmodule

// ----- hdl/gsef_checker.sv -----
// Port-level checks for the grayscale Sobel edge filter, bound to the top level.
module gsef_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pixel_valid,
  input logic                             pixel_ready,
  input logic                             result_valid,
  input logic                             result_ready,
  input logic [gsef_pkg::PIX_W-1:0]       edge_magnitude,
  input logic                             last_of_frame,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [gsef_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [gsef_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [gsef_pkg::APB_DATA_W-1:0]  prdata
);

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(edge_magnitude) && $stable(last_of_frame))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // with the output register empty the pipeline always takes a pixel
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("pixel request blocked with empty output");

  // a register write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !rst |=>
      (paddr[2] != $past(paddr[2])) ||
      (prdata[gsef_pkg::DIM_W-1:0] == $past(pwdata[gsef_pkg::DIM_W-1:0])))
    else $error("register readback mismatch");

endmodule

bind grayscale_sobel_edge_filter gsef_checker u_gsef_checker (
  .clk            (clk),
  .rst            (rst),
  .pixel_valid    (pixel_valid),
  .pixel_ready    (pixel_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .edge_magnitude (edge_magnitude),
  .last_of_frame  (last_of_frame),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
